// ===== rtl/fefu_pkg.sv =====
`timescale 1ns / 1ps
package fefu_pkg;

   localparam int PIXEL_W = 8;
   localparam int COORD_W = 8;
   localparam int CSR_W   = 9;
   localparam int LCG_W   = 16;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [CSR_W-1:0]   csr_data_type;
   typedef logic [LCG_W-1:0]   lcg_type;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam csr_data_type FRAME_WIDTH_RST  = 9'd160;
   localparam csr_data_type FRAME_HEIGHT_RST = 9'd104;

   localparam logic [7:0]  LCG_MUL     = 8'd137;
   localparam logic [7:0]  LCG_INC     = 8'd187;
   localparam logic [5:0]  FILTER_GAIN = 6'd61;

endpackage

// ===== rtl/fefu_req_if.sv =====
`timescale 1ns / 1ps
interface fefu_req_if
   import fefu_pkg::*;
;
   logic      valid;
   logic      ready;
   pixel_type old_pixel;

   modport source (output valid, output old_pixel, input ready);
   modport sink   (input valid, input old_pixel, output ready);
endinterface

// ===== rtl/fefu_rsp_if.sv =====
`timescale 1ns / 1ps
interface fefu_rsp_if
   import fefu_pkg::*;
;
   logic      valid;
   logic      ready;
   pixel_type new_pixel;
   coord_type pixel_row;
   coord_type pixel_col;
   logic      frame_last;

   modport source (output valid, output new_pixel, output pixel_row, output pixel_col,
                   output frame_last, input ready);
   modport sink   (input valid, input new_pixel, input pixel_row, input pixel_col,
                   input frame_last, output ready);
endinterface

// ===== rtl/fefu_ram.sv =====
`timescale 1ns / 1ps
module fefu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // read returns the contents before a same-cycle write
   always_ff @(posedge clock) begin
      read_data_ff <= mem_ff[read_addr];
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/fire_effect_frame_update_top.sv =====
`timescale 1ns / 1ps
// Fire frame update.
// The req channel carries the previous fire frame, one 8-bit pixel per
// transaction in raster order. The rsp channel returns exactly one pixel of
// the new frame per request, with its row, column and a mark on the pixel
// that answers the last input of the frame. Old rows 0 and 1 return the
// seeded bottom rows; every later old row completes the filter for the row
// two above it.
// Throughput is one pixel per clock while the receiver keeps up: the line
// buffer is two copies of a single-write RAM, read ahead for the next pixel,
// with a bypass for the pixel written in the same cycle. rsp.valid rises in
// the cycle after the request transaction. frame_width and frame_height
// are to be written on the csr port between frames; the block itself does
// not enforce this. Reset sets them to 160 and 104, clears the counters,
// the seed generator and the output valid flag; the line buffer holds
// garbage until the first rows of a frame have passed. When the receiver
// stalls, the result is held and req.ready drops until the result is taken.
module fire_effect_frame_update_top
   import fefu_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [0:0]           csr_index,
   input  csr_data_type         csr_wdata,
   fefu_req_if.sink             req,
   fefu_rsp_if.source           rsp
);

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CWW = (WW > CSR_W) ? WW : CSR_W;
   localparam int CHW = (HW > CSR_W) ? HW : CSR_W;

   csr_data_type frame_width_ff;
   csr_data_type frame_height_ff;

   logic [XW-1:0] col_count_ff, col_count_in;
   logic [YW-1:0] row_count_ff, row_count_in;
   pixel_type     left_hold_ff;
   lcg_type       lcg_state_ff, lcg_state_in;
   logic          fwd_a_ff, fwd_b_ff;
   pixel_type     fwd_pixel_ff;

   logic          rsp_valid_ff;
   pixel_type     new_pixel_ff;
   coord_type     pixel_row_ff, pixel_col_ff;
   logic          frame_last_ff;

   logic [CWW-1:0] width_ext;
   logic [CHW-1:0] height_ext;
   logic [WW-1:0]  width_lim, width_m1;
   logic [HW-1:0]  height_lim, height_m1;
   logic           last_col, last_row, seed_row, accept;
   logic [XW-1:0]  rd_addr_a, rd_addr_b;
   pixel_type      ram_a_data, ram_b_data;
   pixel_type      above, side, b_pix, c_pix, value;
   logic [9:0]     tap_sum;
   logic [15:0]    scaled;
   logic [23:0]    lcg_prod;
   logic [HW+7:0]  out_row_full;
   logic [XW+7:0]  out_col_full;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign width_ext  = CWW'(frame_width_ff);
   assign height_ext = CHW'(frame_height_ff);
   assign width_lim  = (width_ext < CWW'(2)) ? WW'(2) :
                       (width_ext > CWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ext);
   assign height_lim = (height_ext < CHW'(3)) ? HW'(3) :
                       (height_ext > CHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_ext);
   assign width_m1   = width_lim - WW'(1);
   assign height_m1  = height_lim - HW'(1);

   // position
   assign last_col = WW'(col_count_ff) >= width_m1;
   assign last_row = HW'(row_count_ff) >= height_m1;
   assign seed_row = row_count_ff < YW'(2);

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept && last_col) begin
         col_count_in = '0;
         row_count_in = last_row ? '0 : row_count_ff + YW'(1);
      end else if (accept) begin
         col_count_in = col_count_ff + XW'(1);
      end
   end

   // line buffer: reads always target the pixel about to be taken
   assign rd_addr_a = col_count_in;
   assign rd_addr_b = col_count_in + XW'(1);

   fefu_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_above_ram (
      .clock      (clock),
      .write_en   (accept),
      .write_addr (col_count_ff),
      .write_data (req.old_pixel),
      .read_addr  (rd_addr_a),
      .read_data  (ram_a_data)
   );

   fefu_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_side_ram (
      .clock      (clock),
      .write_en   (accept),
      .write_addr (col_count_ff),
      .write_data (req.old_pixel),
      .read_addr  (rd_addr_b),
      .read_data  (ram_b_data)
   );

   assign above = fwd_a_ff ? fwd_pixel_ff : ram_a_data;
   assign side  = fwd_b_ff ? fwd_pixel_ff : ram_b_data;

   // filter taps; column 0 reads column 1 through the side port
   always_comb begin
      b_pix = side;
      c_pix = left_hold_ff;
      if (col_count_ff == '0) begin
         c_pix = side;
      end else if (last_col) begin
         b_pix = left_hold_ff;
      end
   end

   assign tap_sum  = 10'(above) + 10'(b_pix) + 10'(c_pix) + 10'(req.old_pixel);
   assign scaled   = 16'(tap_sum) * 16'(FILTER_GAIN);
   assign lcg_prod = 24'(lcg_state_ff) * 24'(LCG_MUL) + 24'(LCG_INC);

   always_comb begin
      lcg_state_in = lcg_state_ff;
      if (seed_row) begin
         lcg_state_in = lcg_prod[LCG_W-1:0];
         value        = {1'b1, lcg_state_in[15:9]};
         out_row_full = (HW+8)'(height_lim) - (HW+8)'(2) + (HW+8)'(row_count_ff);
      end else begin
         value        = scaled[15:8];
         out_row_full = (HW+8)'(row_count_ff) - (HW+8)'(2);
      end
   end

   assign out_col_full = (XW+8)'(col_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         left_hold_ff <= '0;
         lcg_state_ff <= '0;
         fwd_a_ff     <= 1'b0;
         fwd_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         fwd_a_ff     <= accept && (rd_addr_a == col_count_ff);
         fwd_b_ff     <= accept && (rd_addr_b == col_count_ff);
         if (accept) begin
            left_hold_ff <= above;
            lcg_state_ff <= lcg_state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_pixel_ff <= req.old_pixel;
      if (accept) begin
         new_pixel_ff  <= value;
         pixel_row_ff  <= out_row_full[7:0];
         pixel_col_ff  <= out_col_full[7:0];
         frame_last_ff <= last_col && last_row;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.new_pixel  = new_pixel_ff;
   assign rsp.pixel_row  = pixel_row_ff;
   assign rsp.pixel_col  = pixel_col_ff;
   assign rsp.frame_last = frame_last_ff;

endmodule
